@@ rtl/pvsq_pkg.sv @@
// Shared types, constants and coefficient tables for the VCO square-wave block.
package pvsq_pkg;

	localparam int TickRateHz = 1000000;
	localparam int CountBits = 32;
	localparam int AccW = 40;
	localparam int QuotW = $clog2(TickRateHz / 2 + 1);
	localparam int DivW = AccW + 8 + QuotW + 1;
	localparam logic [16:0] CapReset = 17'd1000;

	localparam logic OpTick = 1'b0;
	localparam logic OpUpdate = 1'b1;

	typedef struct packed {
		logic opcode;
		logic [14:0] control_voltage;
		logic [14:0] range_voltage;
		logic enable_n;
	} item_t;

	typedef struct packed {
		logic start;
		logic [14:0] vc;
		logic [14:0] vr;
	} per_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [CountBits-1:0] half_period;
	} per_rsp_t;

	// Q16.16 coefficients of the frequency law, term index 0..4.
	function automatic logic signed [AccW-1:0] coef_a(input logic [2:0] idx);
		logic signed [AccW-1:0] k;
		unique case (idx)
			3'd0: k = 40'sd130447084;
			3'd1: k = 40'sd79102934;
			3'd2: k = 40'sd86946926;
			3'd3: k = -40'sd10158722;
			3'd4: k = 40'sd184710;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic logic signed [AccW-1:0] coef_b(input logic [2:0] idx);
		logic signed [AccW-1:0] k;
		unique case (idx)
			3'd0: k = -40'sd15403186;
			3'd1: k = -40'sd22175273;
			3'd2: k = -40'sd8892898;
			3'd3: k = 40'sd196048;
			3'd4: k = 40'sd110464;
			default: k = '0;
		endcase
		return k;
	endfunction

endpackage

@@ rtl/pvsq_front.sv @@
// Input queue: takes beats from the input channel and holds them for the executor.
module pvsq_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  pvsq_pkg::item_t in_item,
	output logic q_valid,
	output pvsq_pkg::item_t q_item,
	input  logic q_pop
);

	pvsq_pkg::item_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;

	assign in_stall = (count_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (count_q != 2'd0);
	assign q_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

@@ rtl/pvsq_period.sv @@
// Half-period unit: polynomial evaluation on a shared multiplier, then a radix-2 divider.
module pvsq_period (
	input  logic clk,
	input  logic arst_n,
	input  logic cap_we,
	input  logic [16:0] cap_wdata,
	input  pvsq_pkg::per_req_t req,
	output pvsq_pkg::per_rsp_t rsp
);

	typedef enum logic [2:0] {
		P_IDLE, P_MUL, P_ADD, P_SCALE, P_DIV, P_SAT, P_DONE
	} pstate_t;

	typedef enum logic [1:0] {
		POLY_A, POLY_B, POLY_FIN
	} poly_t;

	localparam int BitW = $clog2(pvsq_pkg::QuotW);

	pstate_t state_q;
	poly_t poly_q;
	logic [2:0] idx_q;
	logic [16:0] cap_q;
	logic [14:0] vc_q;
	logic [14:0] vr_q;
	logic signed [pvsq_pkg::AccW-1:0] acc_q;
	logic signed [pvsq_pkg::AccW-1:0] a_q;
	logic signed [pvsq_pkg::AccW+15:0] prod_q;
	logic [pvsq_pkg::DivW-1:0] rem_q;
	logic [pvsq_pkg::DivW-1:0] den_q;
	logic [pvsq_pkg::QuotW-1:0] quot_q;
	logic [BitW-1:0] bit_q;
	logic [pvsq_pkg::CountBits-1:0] hp_q;

	logic signed [pvsq_pkg::AccW+15:0] prod_sh;
	logic signed [pvsq_pkg::AccW-1:0] coef;
	logic signed [pvsq_pkg::AccW-1:0] sum;
	logic [14:0] mul_v;
	logic [16:0] cap_eff;
	logic f_pos;
	logic [pvsq_pkg::AccW+6:0] f100;
	logic [pvsq_pkg::AccW+6:0] cap_sh;
	logic [pvsq_pkg::DivW-1:0] num;
	logic [pvsq_pkg::DivW-1:0] trial;

	assign prod_sh = prod_q >>> 12;
	assign mul_v = (poly_q == POLY_FIN) ? vr_q : vc_q;

	always_comb begin
		unique case (poly_q)
			POLY_A: coef = pvsq_pkg::coef_a(idx_q);
			POLY_B: coef = pvsq_pkg::coef_b(idx_q);
			default: coef = a_q;
		endcase
	end

	assign sum = coef + $signed(prod_sh[pvsq_pkg::AccW-1:0]);

	// The result F sits in acc_q once the final product has been added.
	assign cap_eff = (cap_q == 17'd0) ? 17'd1 : cap_q;
	assign f_pos = !acc_q[pvsq_pkg::AccW-1] && (acc_q != '0);
	assign f100 = {7'd0, acc_q[pvsq_pkg::AccW-1:0]} * (pvsq_pkg::AccW+7)'(100);
	assign cap_sh = (pvsq_pkg::AccW+7)'({cap_eff, 16'd0});
	assign num = ((pvsq_pkg::DivW'(pvsq_pkg::TickRateHz) * pvsq_pkg::DivW'(cap_eff)) << 16)
		+ pvsq_pkg::DivW'(f100);
	assign trial = den_q << bit_q;

	assign rsp.busy = (state_q != P_IDLE) && (state_q != P_DONE);
	assign rsp.done = (state_q == P_DONE);
	assign rsp.half_period = hp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			cap_q <= pvsq_pkg::CapReset;
		end else begin
			if (cap_we) begin
				cap_q <= cap_wdata;
			end
			unique case (state_q)
				P_IDLE, P_DONE: begin
					if (req.start) begin
						vc_q <= req.vc;
						vr_q <= req.vr;
						poly_q <= POLY_A;
						idx_q <= 3'd3;
						acc_q <= pvsq_pkg::coef_a(3'd4);
						state_q <= P_MUL;
					end
				end
				P_MUL: begin
					prod_q <= acc_q * $signed({1'b0, mul_v});
					state_q <= P_ADD;
				end
				P_ADD: begin
					if (poly_q == POLY_FIN) begin
						acc_q <= sum;
						state_q <= P_SCALE;
					end else if (idx_q != 3'd0) begin
						acc_q <= sum;
						idx_q <= idx_q - 3'd1;
						state_q <= P_MUL;
					end else if (poly_q == POLY_A) begin
						a_q <= sum;
						acc_q <= pvsq_pkg::coef_b(3'd4);
						poly_q <= POLY_B;
						idx_q <= 3'd3;
						state_q <= P_MUL;
					end else begin
						acc_q <= sum;
						poly_q <= POLY_FIN;
						state_q <= P_MUL;
					end
				end
				P_SCALE: begin
					bit_q <= BitW'(pvsq_pkg::QuotW - 1);
					rem_q <= num;
					den_q <= pvsq_pkg::DivW'({f100, 1'b0});
					if (!f_pos || (f100 <= cap_sh)) begin
						quot_q <= pvsq_pkg::QuotW'(pvsq_pkg::TickRateHz / 2);
						state_q <= P_SAT;
					end else begin
						quot_q <= '0;
						state_q <= P_DIV;
					end
				end
				P_DIV: begin
					if (rem_q >= trial) begin
						rem_q <= rem_q - trial;
						quot_q[bit_q] <= 1'b1;
					end
					if (bit_q == '0) begin
						state_q <= P_SAT;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				P_SAT: begin
					if (quot_q == '0) begin
						hp_q <= pvsq_pkg::CountBits'(1);
					end else if (64'(quot_q) > 64'({pvsq_pkg::CountBits{1'b1}})) begin
						hp_q <= '1;
					end else begin
						hp_q <= pvsq_pkg::CountBits'(quot_q);
					end
					state_q <= P_DONE;
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/pvsq_back.sv @@
// Executor: runs tick and update beats in order and holds the output register.
module pvsq_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  pvsq_pkg::item_t q_item,
	output logic q_pop,
	output pvsq_pkg::per_req_t req,
	input  pvsq_pkg::per_rsp_t rsp,
	output logic out_valid,
	input  logic out_stall,
	output logic wave_level
);

	typedef enum logic {
		B_EXEC, B_WAIT
	} bstate_t;

	bstate_t state_q;
	logic out_valid_q;
	logic en_latch_q;
	logic toggle_q;
	logic pin_q;
	logic chain_q;
	logic upd_en_q;
	logic [pvsq_pkg::CountBits-1:0] cnt_q;
	logic [pvsq_pkg::CountBits-1:0] half_q;
	logic out_free;
	logic take;
	logic is_tick;
	logic finish_upd;
	logic tick_new;
	logic upd_toggle;

	assign out_free = !out_valid_q || !out_stall;
	assign take = (state_q == B_EXEC) && q_valid && out_free;
	assign is_tick = (q_item.opcode == pvsq_pkg::OpTick);
	assign q_pop = take;
	assign finish_upd = (state_q == B_WAIT) && rsp.done && out_free;

	assign req.start = take && !is_tick;
	assign req.vc = q_item.control_voltage;
	assign req.vr = q_item.range_voltage;

	assign tick_new = en_latch_q ? 1'b1 : ~toggle_q;
	assign upd_toggle = ~toggle_q;

	// The level only moves when a result beat is produced, so it is the output itself.
	assign out_valid = out_valid_q;
	assign wave_level = pin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_EXEC;
			out_valid_q <= 1'b0;
			en_latch_q <= 1'b0;
			toggle_q <= 1'b0;
			pin_q <= 1'b0;
			chain_q <= 1'b1;
			upd_en_q <= 1'b0;
			cnt_q <= '0;
			half_q <= '1;
		end else begin
			out_valid_q <= (out_valid_q && out_stall) || (take && is_tick) || finish_upd;
			unique case (state_q)
				B_EXEC: begin
					if (take && is_tick) begin
						if (chain_q) begin
							if (cnt_q <= pvsq_pkg::CountBits'(1)) begin
								if (!en_latch_q) begin
									toggle_q <= ~toggle_q;
								end
								if (tick_new == pin_q) begin
									chain_q <= 1'b0;
								end else begin
									pin_q <= tick_new;
									cnt_q <= half_q;
								end
							end else begin
								cnt_q <= cnt_q - 1'b1;
							end
						end
					end else if (take) begin
						upd_en_q <= q_item.enable_n;
						state_q <= B_WAIT;
					end
				end
				B_WAIT: begin
					if (finish_upd) begin
						half_q <= rsp.half_period;
						// An enable change flips the toggle; a level move restarts the chain.
						if (upd_en_q != en_latch_q) begin
							en_latch_q <= upd_en_q;
							toggle_q <= upd_toggle;
							if (upd_toggle != pin_q) begin
								pin_q <= upd_toggle;
								chain_q <= 1'b1;
								cnt_q <= rsp.half_period;
							end
						end
						state_q <= B_EXEC;
					end
				end
				default: state_q <= B_EXEC;
			endcase
		end
	end

endmodule

@@ rtl/poly_vco_square_wave_generator.sv @@
// Top level of the voltage-controlled square-wave source.
// Tick beats run at one per clock while the output is not stalled and no update is in progress.
// An update beat evaluates the polynomial on one shared multiplier (a multiply and an add per
// Horner step), scales, forms the half period in a radix-2 divider one quotient bit at a time
// (skipped when the result saturates) and clamps it. Beats after an update wait in a
// two-entry input queue until it has finished.
module poly_vco_square_wave_generator (
	input  logic clk,
	input  logic arst_n,
	input  logic cap_we,
	input  logic [16:0] cap_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  logic opcode,
	input  logic [14:0] control_voltage,
	input  logic [14:0] range_voltage,
	input  logic enable_n,
	output logic out_valid,
	input  logic out_stall,
	output logic wave_level
);

	pvsq_pkg::item_t in_item;
	pvsq_pkg::item_t q_item;
	pvsq_pkg::per_req_t req;
	pvsq_pkg::per_rsp_t rsp;
	logic q_valid;
	logic q_pop;

	assign in_item.opcode = opcode;
	assign in_item.control_voltage = control_voltage;
	assign in_item.range_voltage = range_voltage;
	assign in_item.enable_n = enable_n;

	pvsq_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	pvsq_period u_period (
		.clk(clk),
		.arst_n(arst_n),
		.cap_we(cap_we),
		.cap_wdata(cap_wdata),
		.req(req),
		.rsp(rsp)
	);

	pvsq_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.req(req),
		.rsp(rsp),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.wave_level(wave_level)
	);

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !rsp.busy)
		else $error("period unit started while busy");

	a_start_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> rsp.busy && !rsp.done)
		else $error("period unit did not take the request");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the VCO square-wave generator: directed and random ticks and updates.
module tb;

	localparam logic [63:0] CntMax = (64'd1 << pvsq_pkg::CountBits) - 64'd1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cap_we = 1'b0;
	logic [16:0] cap_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = pvsq_pkg::OpTick;
	logic [14:0] control_voltage = '0;
	logic [14:0] range_voltage = '0;
	logic enable_n = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic wave_level;

	poly_vco_square_wave_generator uut (
		.clk(clk), .arst_n(arst_n), .cap_we(cap_we), .cap_wdata(cap_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.control_voltage(control_voltage), .range_voltage(range_voltage),
		.enable_n(enable_n), .out_valid(out_valid), .out_stall(out_stall),
		.wave_level(wave_level)
	);

	always #2 clk = ~clk;

	// Predictor state.
	logic [63:0] cap_nf;
	logic en_latch, tog_lvl, pin_lvl, chain_on;
	logic [63:0] count_left, half_ticks;

	pvsq_pkg::item_t pending_beats[$];
	logic expected_levels[$];
	int errors = 0;
	int results_seen = 0;
	int updates_sent = 0;
	bit quiet = 1'b0;
	bit in_took = 1'b0;
	int in_gap = 0, out_gap = 0;

	function automatic longint floor_div4096(longint x);
		return x >>> 12;
	endfunction

	function automatic longint eval_poly(logic is_b, longint v);
		longint acc;
		acc = is_b ? longint'(pvsq_pkg::coef_b(3'd4)) : longint'(pvsq_pkg::coef_a(3'd4));
		for (int i = 3; i >= 0; i--)
			acc = (is_b ? longint'(pvsq_pkg::coef_b(i[2:0]))
				: longint'(pvsq_pkg::coef_a(i[2:0])))
				+ floor_div4096(acc * v);
		return acc;
	endfunction

	function automatic logic [63:0] calc_half_period(logic [14:0] vc, logic [14:0] vr);
		logic [63:0] cap, num, den, t;
		longint f;
		cap = (cap_nf == 0) ? 64'd1 : cap_nf;
		f = eval_poly(1'b0, vc) + floor_div4096(eval_poly(1'b1, vc) * longint'(vr));
		if (f <= 0 || 64'(f) * 100 <= cap * 65536) begin
			t = pvsq_pkg::TickRateHz / 2;
		end else begin
			num = 64'(pvsq_pkg::TickRateHz) * cap * 65536;
			den = 200 * 64'(f);
			t = (num + den / 2) / den;
		end
		if (t < 1) t = 1;
		if (t > CntMax) t = CntMax;
		return t;
	endfunction

	function automatic void advance_wave(pvsq_pkg::item_t it);
		logic nl;
		if (it.opcode == pvsq_pkg::OpTick) begin
			if (chain_on) begin
				if (count_left <= 1) begin
					if (!en_latch) begin
						tog_lvl = ~tog_lvl;
						nl = tog_lvl;
					end else begin
						nl = 1'b1;
					end
					if (nl == pin_lvl) begin
						chain_on = 1'b0;
					end else begin
						pin_lvl = nl;
						count_left = half_ticks;
					end
				end else begin
					count_left = count_left - 1;
				end
			end
		end else begin
			half_ticks = calc_half_period(it.control_voltage, it.range_voltage);
			if (it.enable_n != en_latch) begin
				en_latch = it.enable_n;
				tog_lvl = ~tog_lvl;
				if (tog_lvl != pin_lvl) begin
					pin_lvl = tog_lvl;
					chain_on = 1'b1;
					count_left = half_ticks;
				end
			end
		end
		expected_levels.push_back(pin_lvl);
	endfunction

	// Driver: presents beats on the falling edge, advances once a beat is taken, and drives random output stalls.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_took) begin
				void'(pending_beats.pop_front());
			end
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (!(in_valid && !in_took) && !quiet && $urandom_range(0, 15) == 0) begin
				in_gap = $urandom_range(0, 10);
				in_valid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				in_valid <= 1'b1;
				opcode <= pending_beats[0].opcode;
				control_voltage <= pending_beats[0].control_voltage;
				range_voltage <= pending_beats[0].range_voltage;
				enable_n <= pending_beats[0].enable_n;
			end else begin
				in_valid <= 1'b0;
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				out_gap = $urandom_range(0, 10);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: predicts on each accepted input beat and checks each result beat.
	always @(posedge clk) begin
		if (arst_n) begin
			in_took = in_valid && !in_stall;
			if (in_took)
				advance_wave('{opcode, control_voltage, range_voltage, enable_n});
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_levels.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat, expected none, actual %b",
						$time, wave_level);
				end else begin
					if (expected_levels[0] !== wave_level) begin
						errors++;
						$display("%0t: wave_level expected %b, actual %b",
							$time, expected_levels[0], wave_level);
					end
					void'(expected_levels.pop_front());
				end
			end
		end
	end

	task automatic queue_beat(logic op, logic [14:0] vc, logic [14:0] vr, logic en);
		pvsq_pkg::item_t it;
		it.opcode = op;
		it.control_voltage = vc;
		it.range_voltage = vr;
		it.enable_n = en;
		pending_beats.push_back(it);
		if (op == pvsq_pkg::OpUpdate) updates_sent++;
	endtask

	task automatic queue_ticks(int n);
		for (int i = 0; i < n; i++) queue_beat(pvsq_pkg::OpTick, '0, '0, 1'b0);
	endtask

	task automatic drain();
		while (pending_beats.size() > 0 || expected_levels.size() > 0 || in_valid)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_cap(logic [16:0] v);
		@(negedge clk);
		cap_we <= 1'b1;
		cap_wdata <= v;
		@(negedge clk);
		cap_we <= 1'b0;
		cap_nf = v;
	endtask

	// Short fast half periods keep the wave moving; occasional random updates cover the range.
	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 2) == 0)
					queue_beat(pvsq_pkg::OpUpdate, 15'($urandom), 15'($urandom),
						1'($urandom));
				else
					queue_beat(pvsq_pkg::OpUpdate, 15'($urandom_range(20000, 32767)),
						15'($urandom_range(0, 4000)), ($urandom_range(0, 3) == 0));
			end else begin
				queue_ticks(1);
			end
		end
	endtask

	initial begin
		cap_nf = pvsq_pkg::CapReset;
		en_latch = 0; tog_lvl = 0; pin_lvl = 0; chain_on = 1;
		count_left = 0; half_ticks = CntMax;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: first expiry at reset, field extremes, enable edges.
		queue_ticks(2);
		queue_beat(pvsq_pkg::OpUpdate, 15'h7FFF, 15'h7FFF, 1'b0);
		queue_beat(pvsq_pkg::OpUpdate, 15'h0000, 15'h0000, 1'b1);
		queue_ticks(2);
		queue_beat(pvsq_pkg::OpUpdate, 15'h7FFF, 15'h0000, 1'b0);
		queue_beat(pvsq_pkg::OpUpdate, 15'h0000, 15'h7FFF, 1'b1);
		queue_beat(pvsq_pkg::OpUpdate, 15'h5555, 15'h2AAA, 1'b0);
		queue_ticks(3);
		drain();

		write_cap(17'd0);
		queue_beat(pvsq_pkg::OpUpdate, 15'h7FFF, 15'h0000, 1'b1);
		queue_beat(pvsq_pkg::OpUpdate, 15'h7FFF, 15'h0000, 1'b0);
		queue_ticks(4);
		queue_beat(pvsq_pkg::OpUpdate, 15'h2AAA, 15'h5555, 1'b1);
		queue_ticks(3);
		drain();

		write_cap(17'd1);
		random_phase(300);
		drain();
		write_cap(17'h1FFFF);
		random_phase(200);
		drain();
		write_cap(17'd100000);
		random_phase(150);
		drain();
		write_cap(17'($urandom_range(1, 200)));
		random_phase(250);
		drain();
		quiet = 1'b1;
		random_phase(200);
		drain();

		$display("Covered %0d result beats, %0d updates, capacitor settings 0 to max.",
			results_seen, updates_sent);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end
endmodule
